[design/jsu_pkg.sv]
// jsu_pkg: shared types, constants and helper functions for the json string unescaper
// used by json_string_unescaper and jsu_checker; depends on nothing else
package jsu_pkg;

  // input transaction: one raw byte of the string body
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  // output transaction: one decoded byte and/or the closing status
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       string_done;
    logic       status;
  } out_t;

  // parser phase, one-hot
  typedef enum logic [5:0] {
    PH_NORMAL  = 6'b000001,
    PH_ESCAPE  = 6'b000010,
    PH_HEX     = 6'b000100,
    PH_WANT_BS = 6'b001000,
    PH_WANT_U  = 6'b010000,
    PH_LOWHEX  = 6'b100000
  } phase_e;

  // character codes
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_F   = 8'h66;

  // control bytes produced by the short escapes
  localparam logic [7:0] BS_BYTE = 8'h08;
  localparam logic [7:0] FF_BYTE = 8'h0c;
  localparam logic [7:0] LF_BYTE = 8'h0a;
  localparam logic [7:0] CR_BYTE = 8'h0d;
  localparam logic [7:0] HT_BYTE = 8'h09;

  // surrogate ranges
  localparam logic [15:0] HI_SURR_MIN = 16'hd800;
  localparam logic [15:0] HI_SURR_MAX = 16'hdbff;
  localparam logic [15:0] LO_SURR_MIN = 16'hdc00;
  localparam logic [15:0] LO_SURR_MAX = 16'hdfff;
  localparam logic [20:0] SUPP_BASE   = 21'h10000;

  // utf-8 encoding result: bytes in send order and their count
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } utf8_t;

  // hex digit decode: bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= CH_0 && c <= CH_9) begin
      v = c - CH_0;
      return {1'b1, v[3:0]};
    end else if (c >= CH_UC_A && c <= CH_UC_F) begin
      v = c - CH_UC_A + 8'd10;
      return {1'b1, v[3:0]};
    end else if (c >= CH_LC_A && c <= CH_LC_F) begin
      v = c - CH_LC_A + 8'd10;
      return {1'b1, v[3:0]};
    end
    return 5'b0_0000;
  endfunction

  // scalar value to 1..4 utf-8 bytes
  function automatic utf8_t encode_utf8(input logic [20:0] s);
    utf8_t r;
    r = '0;
    if (s <= 21'h7f) begin
      r.b[0] = s[7:0];
      r.n    = 3'd1;
    end else if (s <= 21'h7ff) begin
      r.b[0] = {3'b110, s[10:6]};
      r.b[1] = {2'b10, s[5:0]};
      r.n    = 3'd2;
    end else if (s <= 21'hffff) begin
      r.b[0] = {4'b1110, s[15:12]};
      r.b[1] = {2'b10, s[11:6]};
      r.b[2] = {2'b10, s[5:0]};
      r.n    = 3'd3;
    end else begin
      r.b[0] = {5'b11110, s[20:18]};
      r.b[1] = {2'b10, s[17:12]};
      r.b[2] = {2'b10, s[11:6]};
      r.b[3] = {2'b10, s[5:0]};
      r.n    = 3'd4;
    end
    return r;
  endfunction

endpackage

[design/json_string_unescaper.sv]
// json_string_unescaper: decodes a json string body byte stream into utf-8 bytes
// results of an accepted byte are registered; one byte per cycle unless the output stalls
// an escape that yields n utf-8 bytes holds the result register until all n go (n up to 4)
// input stalls until the last result of a run is taken; the next byte is taken as it goes
// reset: asynchronous, active low; parser returns to pass-through, result register empties
// depends on jsu_pkg
module json_string_unescaper (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  jsu_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output jsu_pkg::out_t out_data_o
);
  import jsu_pkg::*;

  // parser state
  phase_e      ph_q, ph_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] acc_q, acc_d;
  logic [9:0]  hi_q, hi_d;
  logic        err_q, err_d;

  // result register
  logic            res_vld_q, res_vld_d;
  logic [3:0][7:0] res_byte_q;
  logic [2:0]      res_nb_q;
  logic [2:0]      res_tot_q;
  logic [1:0]      res_idx_q, res_idx_d;
  logic            res_eos_q;
  logic            res_stat_q;

  // per-item decode results
  logic [3:0][7:0] dec_byte;
  logic [2:0]      dec_nb;
  logic [2:0]      dec_tot;
  logic            dec_stat;
  logic            fail;
  logic [4:0]      hv;
  logic [15:0]     acc_sh;
  logic [20:0]     pair_scalar;
  utf8_t           enc;

  logic in_acc, out_acc, run_end, res_free, load;
  logic [7:0] b;
  logic       eos;

  assign b   = in_data_i.in_byte;
  assign eos = in_data_i.end_of_string;

  // handshake
  assign run_end     = ({1'b0, res_idx_q} == (res_tot_q - 3'd1));
  assign out_acc     = res_vld_q && !out_stall_i;
  assign res_free    = !res_vld_q || (out_acc && run_end);
  assign in_stall_o  = !res_free;
  assign in_acc      = in_valid_i && res_free;
  assign load        = in_acc && (dec_tot != 3'd0);
  assign out_valid_o = res_vld_q;

  // decode one byte against the parser state
  always_comb begin
    ph_d     = ph_q;
    cnt_d    = cnt_q;
    acc_d    = acc_q;
    hi_d     = hi_q;
    err_d    = err_q;
    dec_byte = '0;
    dec_nb   = 3'd0;
    dec_tot  = 3'd0;
    dec_stat = 1'b0;
    fail     = 1'b0;
    hv       = hex_digit(b);
    acc_sh   = {acc_q[11:0], hv[3:0]};
    pair_scalar = SUPP_BASE + {1'b0, hi_q, acc_sh[9:0]};
    enc      = '0;

    if (!err_q) begin
      unique case (ph_q)
        PH_ESCAPE: begin
          ph_d   = PH_NORMAL;
          dec_nb = 3'd1;
          if (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH) dec_byte[0] = b;
          else if (b == CH_B) dec_byte[0] = BS_BYTE;
          else if (b == CH_F) dec_byte[0] = FF_BYTE;
          else if (b == CH_N) dec_byte[0] = LF_BYTE;
          else if (b == CH_R) dec_byte[0] = CR_BYTE;
          else if (b == CH_T) dec_byte[0] = HT_BYTE;
          else if (b == CH_U) begin
            dec_nb = 3'd0;
            acc_d  = '0;
            cnt_d  = 2'd0;
            ph_d   = PH_HEX;
          end else begin
            fail = 1'b1;
          end
        end
        PH_HEX: begin
          if (!hv[4]) begin
            fail = 1'b1;
          end else begin
            acc_d = acc_sh;
            if (cnt_q != 2'd3) begin
              cnt_d = cnt_q + 2'd1;
            end else begin
              cnt_d = 2'd0;
              if (acc_sh >= LO_SURR_MIN && acc_sh <= LO_SURR_MAX) begin
                fail = 1'b1;
              end else if (acc_sh >= HI_SURR_MIN && acc_sh <= HI_SURR_MAX) begin
                hi_d = acc_sh[9:0];
                ph_d = PH_WANT_BS;
              end else begin
                enc      = encode_utf8({5'd0, acc_sh});
                dec_byte = enc.b;
                dec_nb   = enc.n;
                ph_d     = PH_NORMAL;
              end
            end
          end
        end
        PH_WANT_BS: begin
          if (b == CH_BSLASH) ph_d = PH_WANT_U;
          else fail = 1'b1;
        end
        PH_WANT_U: begin
          if (b == CH_U) begin
            acc_d = '0;
            cnt_d = 2'd0;
            ph_d  = PH_LOWHEX;
          end else begin
            fail = 1'b1;
          end
        end
        PH_LOWHEX: begin
          if (!hv[4]) begin
            fail = 1'b1;
          end else begin
            acc_d = acc_sh;
            if (cnt_q != 2'd3) begin
              cnt_d = cnt_q + 2'd1;
            end else begin
              cnt_d = 2'd0;
              if (acc_sh < LO_SURR_MIN || acc_sh > LO_SURR_MAX) begin
                fail = 1'b1;
              end else begin
                enc      = encode_utf8(pair_scalar);
                dec_byte = enc.b;
                dec_nb   = enc.n;
                ph_d     = PH_NORMAL;
              end
            end
          end
        end
        default: begin
          ph_d = PH_NORMAL;
          if (b == CH_BSLASH) begin
            ph_d = PH_ESCAPE;
          end else begin
            dec_byte[0] = b;
            dec_nb      = 3'd1;
          end
        end
      endcase

      // any failure drops output and suppresses the rest of the string
      if (fail) begin
        err_d    = 1'b1;
        ph_d     = PH_NORMAL;
        cnt_d    = 2'd0;
        dec_byte = '0;
        dec_nb   = 3'd0;
      end
    end

    dec_tot = dec_nb;

    // string end: report status, then return to the reset state
    if (eos) begin
      dec_stat = err_d || (ph_d != PH_NORMAL);
      if (dec_nb == 3'd0) dec_tot = 3'd1;
      ph_d  = PH_NORMAL;
      cnt_d = 2'd0;
      acc_d = '0;
      hi_d  = '0;
      err_d = 1'b0;
    end
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q  <= PH_NORMAL;
      cnt_q <= 2'd0;
      acc_q <= '0;
      hi_q  <= '0;
      err_q <= 1'b0;
    end else if (in_acc) begin
      ph_q  <= ph_d;
      cnt_q <= cnt_d;
      acc_q <= acc_d;
      hi_q  <= hi_d;
      err_q <= err_d;
    end
  end

  // result register control
  always_comb begin
    res_vld_d = res_vld_q;
    res_idx_d = res_idx_q;
    if (load) begin
      res_vld_d = 1'b1;
      res_idx_d = 2'd0;
    end else if (out_acc) begin
      if (run_end) res_vld_d = 1'b0;
      else res_idx_d = res_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
      res_idx_q <= 2'd0;
    end else begin
      res_vld_q <= res_vld_d;
      res_idx_q <= res_idx_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      res_byte_q <= dec_byte;
      res_nb_q   <= dec_nb;
      res_tot_q  <= dec_tot;
      res_eos_q  <= eos;
      res_stat_q <= dec_stat;
    end
  end

  // drive the current result of the run
  always_comb begin
    out_data_o.byte_valid  = ({1'b0, res_idx_q} < res_nb_q);
    out_data_o.out_byte    = out_data_o.byte_valid ? res_byte_q[res_idx_q] : 8'h00;
    out_data_o.run_last    = run_end;
    out_data_o.string_done = run_end && res_eos_q;
    out_data_o.status      = run_end && res_eos_q && res_stat_q;
  end

endmodule

[design/jsu_checker.sv]
// jsu_checker: port-level assertions for json_string_unescaper, bound into each instance
// depends on jsu_pkg and json_string_unescaper
module jsu_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input jsu_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input jsu_pkg::out_t out_data_o
);
  import jsu_pkg::*;

  // a stalled output transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("output transaction changed while stalled");

  // closing result is always the last of its run
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.string_done |-> out_data_o.run_last)
    else $error("string_done without run_last");

  // status only on the closing result
  a_status_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.string_done)
    else $error("status set outside the closing result");

  // a status-only result closes the string and carries a zero byte
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.byte_valid |->
      out_data_o.string_done && (out_data_o.out_byte == 8'h00))
    else $error("byte-less result that does not close the string");

  // the last byte of a string always produces a result in the next cycle
  a_eos_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.end_of_string |=> out_valid_o)
    else $error("string end taken without a closing result");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[verif/tb_json_string_unescaper.sv]
`timescale 1ns / 100ps
// tb_json_string_unescaper: self-checking bench for the json string unescaper
// directed stimulus table, then random strings, with idling on both handshakes
// depends on jsu_pkg and json_string_unescaper
module tb_json_string_unescaper;
  import jsu_pkg::*;

  localparam int RAND_ITEMS   = 350;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PAUSE_STRING = 4;

  // clock, reset and block ports
  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_stall_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  // one row of the directed table; want is used only when fixed is set
  typedef struct {
    in_t  item;
    logic fixed;
    out_t want;
  } dir_row_t;

  dir_row_t   dir_rows [$];
  logic [7:0] body_q [$];
  out_t       decoded_q [$];

  // decoder shadow state
  phase_e      parse_ph;
  logic [1:0]  digit_cnt;
  logic [15:0] hex_word;
  logic [9:0]  hi_bits;
  logic        err_flag;
  logic [7:0]  step_bytes [4];
  int          step_n;
  out_t        step_res [4];
  int          step_cnt;

  // run bookkeeping
  logic calm = 1'b0;
  int   mismatches   = 0;
  int   results_seen = 0;
  int   bytes_in     = 0;
  int   strings_done = 0;
  int   bad_strings  = 0;
  int   cycle_cnt    = 0;

  json_string_unescaper i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // 8 ns clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // hex digit value; bit 4 flags a valid digit, letters (low nibble 1..6) map to 10..15
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return {1'b1, c[3:0]};
    if ((c >= CH_UC_A && c <= CH_UC_F) || (c >= CH_LC_A && c <= CH_LC_F))
      return {1'b1, c[3:0] + 4'd9};
    return 5'b0;
  endfunction

  task automatic clear_parser();
    parse_ph  = PH_NORMAL;
    digit_cnt = '0;
    hex_word  = '0;
    hi_bits   = '0;
    err_flag  = 1'b0;
  endtask

  task automatic put_byte(input logic [7:0] b);
    step_bytes[step_n] = b;
    step_n++;
  endtask

  // scalar value to utf-8 bytes
  task automatic emit_scalar(input logic [20:0] s);
    if (s < 21'h80) begin
      put_byte(s[7:0]);
    end else if (s < 21'h800) begin
      put_byte(8'hc0 | {3'b0, s[10:6]});
      put_byte(8'h80 | {2'b0, s[5:0]});
    end else if (s < 21'h10000) begin
      put_byte(8'he0 | {4'b0, s[15:12]});
      put_byte(8'h80 | {2'b0, s[11:6]});
      put_byte(8'h80 | {2'b0, s[5:0]});
    end else begin
      put_byte(8'hf0 | {5'b0, s[20:18]});
      put_byte(8'h80 | {2'b0, s[17:12]});
      put_byte(8'h80 | {2'b0, s[11:6]});
      put_byte(8'h80 | {2'b0, s[5:0]});
    end
  endtask

  // advance the shadow decoder by one input byte, leave its results in step_res
  task automatic unescape_step(input in_t item);
    logic [7:0] b;
    logic [4:0] nib;
    logic       bad;
    b      = item.in_byte;
    bad    = 1'b0;
    step_n = 0;
    if (!err_flag) begin
      case (parse_ph)
        PH_ESCAPE: begin
          parse_ph = PH_NORMAL;
          case (b)
            CH_QUOTE, CH_BSLASH, CH_SLASH: put_byte(b);
            CH_B: put_byte(BS_BYTE);
            CH_F: put_byte(FF_BYTE);
            CH_N: put_byte(LF_BYTE);
            CH_R: put_byte(CR_BYTE);
            CH_T: put_byte(HT_BYTE);
            CH_U: begin
              hex_word  = '0;
              digit_cnt = '0;
              parse_ph  = PH_HEX;
            end
            default: bad = 1'b1;
          endcase
        end
        PH_HEX, PH_LOWHEX: begin
          nib = nibble_of(b);
          if (!nib[4]) begin
            bad = 1'b1;
          end else begin
            hex_word = {hex_word[11:0], nib[3:0]};
            if (digit_cnt != 2'd3) begin
              digit_cnt++;
            end else if (parse_ph == PH_HEX) begin
              // first escape complete: lone low half, high half or plain scalar
              if (hex_word >= LO_SURR_MIN && hex_word <= LO_SURR_MAX) begin
                bad = 1'b1;
              end else if (hex_word >= HI_SURR_MIN && hex_word <= HI_SURR_MAX) begin
                hi_bits  = hex_word[9:0];
                parse_ph = PH_WANT_BS;
              end else begin
                emit_scalar({5'b0, hex_word});
                parse_ph = PH_NORMAL;
              end
            end else if (hex_word < LO_SURR_MIN || hex_word > LO_SURR_MAX) begin
              bad = 1'b1;
            end else begin
              emit_scalar(SUPP_BASE + {1'b0, hi_bits, hex_word[9:0]});
              parse_ph = PH_NORMAL;
            end
          end
        end
        PH_WANT_BS: begin
          if (b == CH_BSLASH) parse_ph = PH_WANT_U;
          else bad = 1'b1;
        end
        PH_WANT_U: begin
          if (b == CH_U) begin
            hex_word  = '0;
            digit_cnt = '0;
            parse_ph  = PH_LOWHEX;
          end else begin
            bad = 1'b1;
          end
        end
        default: begin
          parse_ph = PH_NORMAL;
          if (b == CH_BSLASH) parse_ph = PH_ESCAPE;
          else put_byte(b);
        end
      endcase
      if (bad) begin
        err_flag = 1'b1;
        parse_ph = PH_NORMAL;
        step_n   = 0;
      end
    end

    // string end: anything left half-parsed is an error, and a status result always goes out
    step_cnt = step_n;
    if (item.end_of_string) begin
      if (parse_ph != PH_NORMAL) err_flag = 1'b1;
      if (step_cnt == 0) step_cnt = 1;
    end
    for (int k = 0; k < step_cnt; k++) begin
      step_res[k].out_byte    = (k < step_n) ? step_bytes[k] : 8'h00;
      step_res[k].byte_valid  = (k < step_n);
      step_res[k].run_last    = (k == step_cnt - 1);
      step_res[k].string_done = (k == step_cnt - 1) && item.end_of_string;
      step_res[k].status      = step_res[k].string_done & err_flag;
    end
    if (item.end_of_string) begin
      strings_done++;
      if (err_flag) bad_strings++;
      clear_parser();
    end
  endtask

  task automatic predict_item(input in_t item);
    unescape_step(item);
    for (int k = 0; k < step_cnt; k++) decoded_q.push_back(step_res[k]);
  endtask

  // sender: random gap, then hold valid until the transaction is taken
  task automatic drive_item(input in_t item);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    bytes_in++;
  endtask

  // directed table entries
  task automatic add_row(input logic [7:0] b, input logic eos);
    dir_row_t row;
    row.item.in_byte       = b;
    row.item.end_of_string = eos;
    row.fixed              = 1'b0;
    row.want               = '0;
    dir_rows.push_back(row);
  endtask

  task automatic add_closing(input logic [7:0] b, input logic [7:0] ob, input logic bv,
                             input logic st);
    dir_row_t row;
    row.item.in_byte       = b;
    row.item.end_of_string = 1'b1;
    row.fixed              = 1'b1;
    row.want.out_byte      = ob;
    row.want.byte_valid    = bv;
    row.want.run_last      = 1'b1;
    row.want.string_done   = 1'b1;
    row.want.status        = st;
    dir_rows.push_back(row);
  endtask

  // random content helpers
  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (c == CH_BSLASH);
    return c;
  endfunction

  function automatic logic [15:0] rand_bmp();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: v = 16'($urandom_range(0, 'h7f));
      1: v = 16'($urandom_range('h80, 'h7ff));
      default: v = 16'($urandom_range(0, 'hffff));
    endcase
    // move out of the surrogate block
    if (v >= HI_SURR_MIN && v <= LO_SURR_MAX) v[14] = ~v[14];
    return v;
  endfunction

  function automatic logic [15:0] rand_half(input logic [15:0] base);
    return base | 16'($urandom_range(0, 'h3ff));
  endfunction

  // four hex digits, letter case picked per digit
  task automatic push_u(input logic [15:0] v);
    logic [3:0] d;
    body_q.push_back(CH_BSLASH);
    body_q.push_back(CH_U);
    for (int i = 3; i >= 0; i--) begin
      d = v[i*4 +: 4];
      if (d < 4'd10) body_q.push_back(CH_0 + 8'(d));
      else if ($urandom_range(0, 1) == 0) body_q.push_back(CH_UC_A + 8'(d) - 8'd10);
      else body_q.push_back(CH_LC_A + 8'(d) - 8'd10);
    end
  endtask

  // append one token to body_q; cut is set when the string must end right here
  task automatic add_token(output logic cut);
    int         pick;
    int         keep;
    logic [7:0] c;
    logic [4:0] nib;
    pick = $urandom_range(0, 99);
    cut  = 1'b0;
    if (pick < 30) begin
      body_q.push_back(rand_plain());
    end else if (pick < 48) begin
      // two-byte escape
      body_q.push_back(CH_BSLASH);
      case ($urandom_range(0, 7))
        0: body_q.push_back(CH_QUOTE);
        1: body_q.push_back(CH_BSLASH);
        2: body_q.push_back(CH_SLASH);
        3: body_q.push_back(CH_B);
        4: body_q.push_back(CH_F);
        5: body_q.push_back(CH_N);
        6: body_q.push_back(CH_R);
        default: body_q.push_back(CH_T);
      endcase
    end else if (pick < 62) begin
      push_u(rand_bmp());
    end else if (pick < 76) begin
      push_u(rand_half(HI_SURR_MIN));
      push_u(rand_half(LO_SURR_MIN));
    end else if (pick < 80) begin
      // unknown escape letter
      do begin
        c = 8'($urandom_range(0, 255));
      end while (c inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T,
                           CH_U});
      body_q.push_back(CH_BSLASH);
      body_q.push_back(c);
    end else if (pick < 84) begin
      // non-hex byte inside a \u escape, first or second half
      if ($urandom_range(0, 1) == 0) push_u(rand_half(HI_SURR_MIN));
      body_q.push_back(CH_BSLASH);
      body_q.push_back(CH_U);
      repeat ($urandom_range(0, 3)) body_q.push_back(CH_0 + 8'($urandom_range(0, 9)));
      do begin
        c   = 8'($urandom_range(0, 255));
        nib = nibble_of(c);
      end while (nib[4]);
      body_q.push_back(c);
    end else if (pick < 88) begin
      push_u(rand_half(LO_SURR_MIN));
    end else if (pick < 94) begin
      // high half whose partner never shows up
      push_u(rand_half(HI_SURR_MIN));
      case ($urandom_range(0, 2))
        0: body_q.push_back(rand_plain());
        1: begin
          do begin
            c = 8'($urandom_range(0, 255));
          end while (c == CH_U);
          body_q.push_back(CH_BSLASH);
          body_q.push_back(c);
        end
        default: push_u(($urandom_range(0, 1) == 0) ? rand_bmp() : rand_half(HI_SURR_MIN));
      endcase
    end else begin
      // escape cut off by the end of the string
      keep = body_q.size() + $urandom_range(1, 11);
      push_u(rand_half(HI_SURR_MIN));
      push_u(rand_half(LO_SURR_MIN));
      while (body_q.size() > keep) void'(body_q.pop_back());
      cut = 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // receiver: random stall before each result transaction
  initial begin
    int unsigned hold;
    wait (rst_ni);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 3);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(posedge clk_i);
      end while (!(out_valid_o && !out_stall_i));
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (decoded_q.size() == 0) begin
        $display("%0t: result with nothing expected, got byte %0h valid %0b done %0b status %0b",
                 $time, out_data_o.out_byte, out_data_o.byte_valid,
                 out_data_o.string_done, out_data_o.status);
        mismatches++;
      end else begin
        want = decoded_q.pop_front();
        check_field("out_byte", want.out_byte, out_data_o.out_byte);
        check_field("byte_valid", 8'(want.byte_valid), 8'(out_data_o.byte_valid));
        check_field("run_last", 8'(want.run_last), 8'(out_data_o.run_last));
        check_field("string_done", 8'(want.string_done), 8'(out_data_o.string_done));
        check_field("status", 8'(want.status), 8'(out_data_o.status));
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("json_string_unescaper test failed");
      $finish;
    end
  end

  // reset, directed table, random strings, drain
  initial begin
    in_t item;
    int  rand_items;
    int  strings_sent;
    int  ntok;
    logic cut;
    rand_items   = 0;
    strings_sent = 0;
    clear_parser();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // byte extremes pass through
    add_row(8'h00, 1'b0);
    add_closing(8'hff, 8'hff, 1'b1, 1'b0);
    // short escape closing a string
    add_row(CH_BSLASH, 1'b0);
    add_closing(CH_N, LF_BYTE, 1'b1, 1'b0);
    // string ends right after a backslash
    add_closing(CH_BSLASH, 8'h00, 1'b0, 1'b1);
    // largest bmp scalar, mixed case digits
    add_row(CH_BSLASH, 1'b0);
    add_row(CH_U, 1'b0);
    add_row("F", 1'b0);
    add_row("f", 1'b0);
    add_row("F", 1'b0);
    add_row("f", 1'b0);
    // largest surrogate pair, closing the string
    add_row(CH_BSLASH, 1'b0);
    add_row(CH_U, 1'b0);
    add_row("D", 1'b0);
    add_row("b", 1'b0);
    add_row("F", 1'b0);
    add_row("F", 1'b0);
    add_row(CH_BSLASH, 1'b0);
    add_row(CH_U, 1'b0);
    add_row("d", 1'b0);
    add_row("F", 1'b0);
    add_row("f", 1'b0);
    add_row("f", 1'b1);
    // unknown escape letter on the last byte
    add_row(CH_BSLASH, 1'b0);
    add_closing("x", 8'h00, 1'b0, 1'b1);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].fixed) begin
        unescape_step(dir_rows[r].item);
        decoded_q.push_back(dir_rows[r].want);
      end else begin
        predict_item(dir_rows[r].item);
      end
      drive_item(dir_rows[r].item);
    end

    // random strings, mostly well-formed escapes with some broken ones mixed in
    while (rand_items < RAND_ITEMS) begin
      body_q.delete();
      calm = ($urandom_range(0, 5) == 0);
      ntok = $urandom_range(1, 6);
      cut  = 1'b0;
      for (int t = 0; t < ntok && !cut; t++) add_token(cut);
      foreach (body_q[i]) begin
        item.in_byte       = body_q[i];
        item.end_of_string = (i == body_q.size() - 1);
        predict_item(item);
        drive_item(item);
        rand_items++;
      end
      strings_sent++;
      if (strings_sent == PAUSE_STRING) begin
        // sender holds off until every pending result is out
        in_valid_i <= 1'b0;
        do begin
          @(posedge clk_i);
        end while (decoded_q.size() != 0);
      end
    end

    // drain
    in_valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (decoded_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("ran %0d strings (%0d with bad or cut-off escapes), %0d bytes in, %0d results out",
             strings_done, bad_strings, bytes_in, results_seen);
    $display("stimulus: byte extremes, all short escapes, \\u in both cases, surrogate pairs");
    if (mismatches == 0) begin
      $display("json_string_unescaper test passed");
    end else begin
      $display("json_string_unescaper test failed");
    end
    $finish;
  end

endmodule
